// ===== design/dss_pkg.sv =====
// Shared types and codes for the dual stack shared memory block.
package dss_pkg;

    localparam int unsigned WORD_W = 32;

    // Command codes
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    // Status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_OVERFLOW = 2'd1;
    localparam logic [1:0] STS_EMPTY    = 2'd2;

    typedef struct packed {
        logic [1:0]               cmd;
        logic                     stack_select;
        logic signed [WORD_W-1:0] push_value;
    } dss_req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic [1:0]               status;
    } dss_rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the request transaction this cycle
        logic capture;  // load RAM read data into the result register
    } dss_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic need_read;  // presented request pops or peeks a non-empty stack
    } dss_sts_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WAIT = 3'b010,
        ST_OUT  = 3'b100
    } dss_state_t;

endpackage

// ===== design/dss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/dss_ctrl.sv =====
// Transaction sequencing state machine for the dual stack block.
module dss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  dss_pkg::dss_sts_t sts,
    output dss_pkg::dss_ctl_t ctl
);
    import dss_pkg::*;

    dss_state_t state_reg;
    dss_state_t state_next;
    logic       take_out;
    logic       ready;
    logic       accept;

    assign take_out = (state_reg == ST_OUT) && !rsp_stall;
    // Result register frees up in the same cycle it is taken.
    assign ready    = (state_reg == ST_IDLE) || take_out;
    assign accept   = ready && req_valid;

    assign req_stall   = !ready;
    assign rsp_valid   = (state_reg == ST_OUT);
    assign ctl.accept  = accept;
    assign ctl.capture = (state_reg == ST_WAIT);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = sts.need_read ? ST_WAIT : ST_OUT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (accept)
                begin
                    state_next = sts.need_read ? ST_WAIT : ST_OUT;
                end
                else if (take_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_read_then_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.accept && sts.need_read) |=> ctl.capture)
        else $error("read request not followed by capture");

    a_capture_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.capture |=> (rsp_valid && !ctl.capture))
        else $error("capture not followed by response");

    a_no_accept_on_capture: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.accept && ctl.capture))
        else $error("request accepted while read in flight");

endmodule

// ===== design/dss_dpath.sv =====
// Stack counters, address generation, shared RAM and result register.
module dss_dpath #(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dss_pkg::dss_req_t req,
    output dss_pkg::dss_rsp_t rsp,
    input  dss_pkg::dss_ctl_t ctl,
    output dss_pkg::dss_sts_t sts
);
    import dss_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [CW-1:0]     lower_count_reg;
    logic [CW-1:0]     lower_count_next;
    logic [CW-1:0]     upper_count_reg;
    logic [CW-1:0]     upper_count_next;
    logic [CW:0]       used_sum;
    logic              full;
    logic [CW-1:0]     sel_count;
    logic              empty;
    logic              is_push;
    logic              is_read;
    logic              do_write;
    logic              do_read;
    logic [CW-1:0]     upper_wr_pos;
    logic [CW-1:0]     upper_rd_pos;
    logic [CW-1:0]     lower_rd_pos;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;
    dss_rsp_t          result_reg;
    dss_rsp_t          result_next;

    assign used_sum  = {1'b0, lower_count_reg} + {1'b0, upper_count_reg};
    assign full      = (used_sum >= (CW+1)'(DEPTH));
    assign sel_count = req.stack_select ? upper_count_reg : lower_count_reg;
    assign empty     = (sel_count == '0);
    assign is_push   = (req.cmd == CMD_PUSH);
    assign is_read   = (req.cmd inside {CMD_POP, CMD_PEEK});

    assign sts.need_read = is_read && !empty;

    assign do_write = ctl.accept && is_push && !full;
    assign do_read  = ctl.accept && sts.need_read;

    // Upper stack lives at DEPTH-upper_count .. DEPTH-1.
    assign upper_wr_pos = CW'(DEPTH - 1) - upper_count_reg;
    assign upper_rd_pos = CW'(DEPTH) - upper_count_reg;
    assign lower_rd_pos = lower_count_reg - CW'(1);

    assign wr_addr = req.stack_select ? upper_wr_pos[AW-1:0] : lower_count_reg[AW-1:0];
    assign rd_addr = req.stack_select ? upper_rd_pos[AW-1:0] : lower_rd_pos[AW-1:0];

    dss_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (do_write),
        .wr_addr (wr_addr),
        .wr_data (req.push_value),
        .rd_en   (do_read),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        lower_count_next = lower_count_reg;
        upper_count_next = upper_count_reg;
        if (do_write)
        begin
            if (req.stack_select)
            begin
                upper_count_next = upper_count_reg + CW'(1);
            end
            else
            begin
                lower_count_next = lower_count_reg + CW'(1);
            end
        end
        else if (do_read && (req.cmd == CMD_POP))
        begin
            if (req.stack_select)
            begin
                upper_count_next = upper_count_reg - CW'(1);
            end
            else
            begin
                lower_count_next = lower_count_reg - CW'(1);
            end
        end
    end

    always_comb
    begin
        result_next = result_reg;
        if (ctl.capture)
        begin
            result_next.read_value = rd_data;
            result_next.status     = STS_OK;
        end
        else if (ctl.accept)
        begin
            result_next.read_value = '0;
            result_next.status     = STS_OK;
            case (req.cmd)
                CMD_PUSH:
                begin
                    if (full)
                    begin
                        result_next.status = STS_OVERFLOW;
                    end
                end
                CMD_POP, CMD_PEEK:
                begin
                    if (empty)
                    begin
                        result_next.read_value = '1;
                        result_next.status     = STS_EMPTY;
                    end
                end
                default:
                begin
                    result_next.status = STS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_count_reg <= '0;
            upper_count_reg <= '0;
        end
        else
        begin
            lower_count_reg <= lower_count_next;
            upper_count_reg <= upper_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign rsp = result_reg;

    a_never_overfilled: assert property (@(posedge clk) disable iff (!rst_n)
        used_sum <= (CW+1)'(DEPTH))
        else $error("stacks hold more words than the memory");

    a_pop_lower_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_read && (req.cmd == CMD_POP) && !req.stack_select)
        |=> (lower_count_reg == $past(lower_count_reg) - CW'(1)))
        else $error("lower pop did not shrink the stack");

endmodule

// ===== design/dual_stack_shared_memory.sv =====
// Top level: two LIFO stacks sharing one RAM, lower grows up, upper grows down.
// Response path: push, empty pop/peek and unused commands respond from the result register
//   loaded at accept; a pop or peek of a non-empty stack goes through the registered RAM read first.
// Throughput: one transaction per cycle without RAM reads while the receiver does not stall;
//   a RAM read blocks new requests until its data is captured (single read port, registered data).
// Reset (rst_n, async low): both stack counts cleared and controller idle;
//   RAM contents are not cleared, a word is only read after it was pushed.
module dual_stack_shared_memory #(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  dss_pkg::dss_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output dss_pkg::dss_rsp_t rsp
);
    import dss_pkg::*;

    // Controller and datapath talk only through these two groups.
    dss_ctl_t ctl;
    dss_sts_t sts;

    // Sequencing: idle -> (wait for RAM data) -> response held until taken.
    // A new request transaction is taken in the cycle the response leaves.
    dss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // Counters, full/empty checks, RAM and the response register.
    dss_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .ctl   (ctl),
        .sts   (sts)
    );

endmodule

// ===== bench/tb.sv =====
// Testbench for dual_stack_shared_memory: random push/pop/peek traffic checked against a predictor.
`timescale 1ns / 1ps

module tb;

    import dss_pkg::*;

    localparam int DEPTH = 64;
    // cmd 3 is not a real operation; the block answers 0 / OK and changes nothing
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int N_RANDOM = 1350;
    localparam int IDLE_PCT = 31;
    // window of cycles with no idling on either side
    localparam int QUIET_FROM = 2000;
    localparam int QUIET_TO   = 3000;
    // receiver hold-off: starts once this many requests were taken; HOLD_LEN sets its length
    localparam int HOLD_AT  = 400;
    localparam int HOLD_LEN = 250;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    dss_req_t req = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    dss_rsp_t rsp;

    dss_req_t pending_reqs[$];    // request transactions not yet presented
    dss_rsp_t expected_rsps[$];   // predicted responses, oldest first

    // predictor state: shared word array and the two stack depths
    logic [WORD_W-1:0] word_mem [0:DEPTH-1];
    int unsigned       lower_cnt = 0;
    int unsigned       upper_cnt = 0;

    int  err_cnt = 0;
    int  accepted_cnt = 0;
    int  cyc = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  req_taken = 1'b0;   // request accepted at the last rising edge

    dual_stack_shared_memory #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    // Apply one request to the predictor state and return the response it should yield.
    function automatic dss_rsp_t stack_step(input dss_req_t r);
        dss_rsp_t    o;
        int unsigned cnt;
        int unsigned addr;
        o.read_value = '0;
        o.status     = STS_OK;
        case (r.cmd)
            CMD_PUSH:
            begin
                if (lower_cnt + upper_cnt >= DEPTH)
                    o.status = STS_OVERFLOW;   // no free word between the tops
                else if (r.stack_select == 1'b0)
                begin
                    word_mem[lower_cnt] = r.push_value;
                    lower_cnt++;
                end
                else
                begin
                    upper_cnt++;
                    word_mem[DEPTH - upper_cnt] = r.push_value;
                end
            end
            CMD_POP, CMD_PEEK:
            begin
                cnt = (r.stack_select == 1'b0) ? lower_cnt : upper_cnt;
                if (cnt == 0)
                begin
                    // only the addressed stack is tested for emptiness
                    o.read_value = '1;
                    o.status     = STS_EMPTY;
                end
                else
                begin
                    addr = (r.stack_select == 1'b0) ? lower_cnt - 1 : DEPTH - upper_cnt;
                    o.read_value = word_mem[addr];
                    if (r.cmd == CMD_POP)
                    begin
                        if (r.stack_select == 1'b0)
                            lower_cnt--;
                        else
                            upper_cnt--;
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic add_req(input logic [1:0] c, input logic s, input logic [WORD_W-1:0] v);
        dss_req_t r;
        r.cmd          = c;
        r.stack_select = s;
        r.push_value   = v;
        pending_reqs.push_back(r);
    endtask

    // Random part: segments that lean toward filling, draining or mixing, so the
    // stacks repeatedly reach full memory and go back to empty.
    task automatic add_random_reqs();
        int          n;
        int          seg_len;
        int          push_pct;
        int          sel_pct;
        int          roll;
        logic [1:0]  c;
        n = 0;
        while (n < N_RANDOM)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    push_pct = 85;
                    seg_len  = $urandom_range(60, 160);
                end
                1:
                begin
                    push_pct = 10;
                    seg_len  = $urandom_range(40, 140);
                end
                default:
                begin
                    push_pct = 45;
                    seg_len  = $urandom_range(20, 100);
                end
            endcase
            sel_pct = $urandom_range(0, 2) * 40 + 10;   // 10, 50 or 90 percent upper stack
            repeat (seg_len)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                    c = CMD_UNUSED;                     // a little noise
                else if (roll < push_pct)
                    c = CMD_PUSH;
                else if ($urandom_range(0, 99) < 60)
                    c = CMD_POP;
                else
                    c = CMD_PEEK;
                add_req(c, $urandom_range(0, 99) < sel_pct, $urandom);
                n++;
            end
        end
    endtask

    // Cycle counter, used for the quiet window
    always @(posedge clk)
        cyc <= cyc + 1;

    // Driver: presents request transactions at the falling edge. A stalled
    // request stays put; otherwise the next one is offered unless we idle.
    always @(negedge clk)
    begin
        if (!rst_n)
            req_valid <= 1'b0;
        else if (req_valid && !req_taken)
            ;   // still waiting to be accepted
        else if (pending_reqs.size() != 0 &&
                 ((cyc >= QUIET_FROM && cyc < QUIET_TO) || $urandom_range(0, 99) >= IDLE_PCT))
        begin
            req       <= pending_reqs.pop_front();
            req_valid <= 1'b1;
        end
        else
            req_valid <= 1'b0;
    end

    // Receiver stall. Once, a long hold-off lets the block back up into its input.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else if (!hold_done && accepted_cnt >= HOLD_AT)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            rsp_stall <= 1'b1;
        end
        else if (cyc >= QUIET_FROM && cyc < QUIET_TO)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Monitor: predicts on each accepted request and checks each accepted response.
    always @(posedge clk)
    begin
        dss_rsp_t want;
        if (rst_n)
        begin
            req_taken <= req_valid && !req_stall;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                    report_mismatch($sformatf("response with nothing pending: value %h status %0d",
                                              rsp.read_value, rsp.status));
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value %h, predicted %h",
                                                  rsp.read_value, want.read_value));
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  rsp.status, want.status));
                end
            end
            if (req_valid && !req_stall)
            begin
                expected_rsps.push_back(stack_step(req));
                accepted_cnt <= accepted_cnt + 1;
            end
        end
    end

    initial
    begin
        // Directed opening: empty reads of both stacks, unused command,
        // extreme words on both stacks, LIFO order, and empty again.
        add_req(CMD_POP,    1'b0, '0);
        add_req(CMD_PEEK,   1'b1, '0);
        add_req(CMD_POP,    1'b1, 32'h1234_5678);
        add_req(CMD_PEEK,   1'b0, '1);
        add_req(CMD_UNUSED, 1'b0, 32'hFFFF_FFFF);
        add_req(CMD_UNUSED, 1'b1, 32'h0000_0000);
        add_req(CMD_PUSH,   1'b0, 32'h7FFF_FFFF);
        add_req(CMD_PUSH,   1'b1, 32'h8000_0000);
        add_req(CMD_PUSH,   1'b0, 32'h0000_0000);
        add_req(CMD_PUSH,   1'b1, 32'hFFFF_FFFF);
        add_req(CMD_PEEK,   1'b0, '0);
        add_req(CMD_PEEK,   1'b1, '0);
        add_req(CMD_POP,    1'b0, '0);
        add_req(CMD_POP,    1'b0, '0);
        add_req(CMD_POP,    1'b0, '0);   // lower empty, upper still holds two
        add_req(CMD_PEEK,   1'b0, '0);
        add_req(CMD_POP,    1'b1, '0);
        add_req(CMD_PEEK,   1'b1, '0);
        add_req(CMD_POP,    1'b1, '0);
        add_req(CMD_POP,    1'b1, '0);
        add_req(CMD_PUSH,   1'b1, 32'h5555_AAAA);
        add_req(CMD_UNUSED, 1'b1, 32'hAAAA_5555);
        add_req(CMD_PEEK,   1'b1, '0);
        add_random_reqs();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain: every request taken, then every response seen, then a final idle wait
        while (pending_reqs.size() != 0 || req_valid)
            @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_rsps.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));

        if (err_cnt == 0)
            $display("dual_stack_shared_memory: match");
        else
            $display("dual_stack_shared_memory: mismatch");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("TIMEOUT @%0t", $time);
        $display("dual_stack_shared_memory: mismatch");
        $finish;
    end

endmodule
